// File: hdl/dfc_pkg.sv
// Shared types, constants and functions of the display frame builder.
`timescale 1ns / 1ps

package dfc_pkg;

    // Input and output field widths
    localparam int VALUE_W = 14;
    localparam int BYTE_W  = 8;
    localparam int LEAD_W  = 48;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

    // Frame layout
    localparam int FRAME_LEN  = 17;
    localparam int LEAD_LEN   = 6;
    localparam int CRC_SPAN   = 15;
    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int FRAME_LAST = FRAME_LEN - 1;

    // CRC-16/XMODEM
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // APB register map: 64-bit registers at 8-byte steps
    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;
    localparam logic REG_LEAD  = 1'b0;
    localparam logic REG_TRAIL = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [3:0]       t_digit;
    // element 3 is the thousands digit
    typedef t_digit [3:0]     t_bcd;

    typedef struct packed {
        t_bcd val_b;
        t_bcd val_a;
    } t_digit_set;

    typedef struct packed {
        logic [LEAD_W-1:0] lead_bytes;
        logic [BYTE_W-1:0] trail_byte;
    } t_cfg;

    // Saturate to 0..9999 and split into four decimal digits.
    function automatic t_bcd to_digits(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] vc;
        logic [9:0]         r1;
        logic [6:0]         r2;
        logic [3:0]         r3;
        t_bcd               d;
        vc = (v > VALUE_MAX) ? VALUE_MAX : v;
        d  = '0;
        r1 = vc[9:0];
        for (int k = 1; k < 10; k++) begin
            if (vc >= 14'(k * 1000)) begin
                d[3] = 4'(k);
                r1   = 10'(vc - 14'(k * 1000));
            end
        end
        r2 = r1[6:0];
        for (int k = 1; k < 10; k++) begin
            if (r1 >= 10'(k * 100)) begin
                d[2] = 4'(k);
                r2   = 7'(r1 - 10'(k * 100));
            end
        end
        r3 = r2[3:0];
        for (int k = 1; k < 10; k++) begin
            if (r2 >= 7'(k * 10)) begin
                d[1] = 4'(k);
                r3   = 4'(r2 - 7'(k * 10));
            end
        end
        d[0] = r3;
        return d;
    endfunction

    // One byte of CRC-16/XMODEM, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [BYTE_W-1:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hdl/dfc_if.sv
// Valid/ready channel interfaces for the input items and the frame bytes.
`timescale 1ns / 1ps

interface dfc_in_if import dfc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_a;
    logic [VALUE_W-1:0] value_b;

    modport source (output valid, value_a, value_b, input ready);
    modport sink   (input valid, value_a, value_b, output ready);
endinterface

interface dfc_out_if import dfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

// File: hdl/digit_frame_crc16_builder_core.sv
// Top level of the display frame builder with CRC-16/XMODEM.
`timescale 1ns / 1ps

// Each input item carries two display values (value_a, value_b, 14 bits each,
// saturated to 9999) and yields one 17-byte frame on the output channel, one
// byte per transfer, byte 0 first: bytes 0-5 from lead_bytes (byte 0 in bits
// 47:40), bytes 6-9 the decimal digits of value_b and bytes 10-13 those of
// value_a (most significant first, plain 0..9), byte 14 trail_byte, bytes
// 15-16 the CRC-16/XMODEM of bytes 0-14, high byte first; last_byte marks
// byte 16. The single output register sends one byte a cycle while the sink
// keeps ready high. The input digit register takes the next item while a
// frame is still going out, so frames leave back to back; on an idle block
// the first byte of a frame passes the digit register and then the output
// register. Registers (APB, 64-bit data): lead_bytes at 0x0, trail_byte at
// 0x8; pready is tied high. Write them only while no frame is in flight.
module digit_frame_crc16_builder_core import dfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dfc_in_if.sink            i_in,
    dfc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    logic       dig_valid;
    t_digit_set dig_set;
    logic       dig_take;

    // configuration registers
    dfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register: saturate and split into digits
    dfc_digits u_digits (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_take   (dig_take),
        .o_valid  (dig_valid),
        .o_digits (dig_set)
    );

    // byte serializer with running CRC
    dfc_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_up_valid  (dig_valid),
        .i_up_digits (dig_set),
        .o_up_ready  (dig_take),
        .o_out       (o_out)
    );

endmodule

// File: hdl/dfc_cfg.sv
// APB register block: lead bytes and trail byte.
`timescale 1ns / 1ps

module dfc_cfg import dfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [LEAD_W-1:0] r_lead;
    logic [BYTE_W-1:0] r_trail;
    logic              wr_en;
    logic              reg_sel;

    // registers sit at 8-byte steps; the low address bits select nothing
    assign reg_sel = paddr[3];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_trail <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_LEAD:  r_lead  <= pwdata[LEAD_W-1:0];
                REG_TRAIL: r_trail <= pwdata[BYTE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LEAD:  prdata = {{(DATA_W-LEAD_W){1'b0}}, r_lead};
            REG_TRAIL: prdata = {{(DATA_W-BYTE_W){1'b0}}, r_trail};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.lead_bytes = r_lead;
    assign o_cfg.trail_byte = r_trail;

endmodule

// File: hdl/dfc_digits.sv
// Input register stage: saturate both values and hold their decimal digits.
`timescale 1ns / 1ps

module dfc_digits import dfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfc_in_if.sink     i_in,
    input  logic       i_take,
    output logic       o_valid,
    output t_digit_set o_digits
);

    logic       r_valid;
    t_digit_set r_digits;
    logic       accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_digits.val_a <= to_digits(i_in.value_a);
            r_digits.val_b <= to_digits(i_in.value_b);
        end
    end

    assign o_valid  = r_valid;
    assign o_digits = r_digits;

    // a held item is not dropped while the serializer is busy
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |=> r_valid)
        else $error("digit stage lost an item");

    // the thousands and units digits of both stored values are decimal
    a_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_digits.val_a[3] <= 4'd9 && r_digits.val_a[0] <= 4'd9
                  && r_digits.val_b[3] <= 4'd9 && r_digits.val_b[0] <= 4'd9))
        else $error("digit out of range");

endmodule

// File: hdl/dfc_serial.sv
// Frame serializer: byte select, running CRC, output register.
`timescale 1ns / 1ps

module dfc_serial import dfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_up_valid,
    input  t_digit_set i_up_digits,
    output logic       o_up_ready,
    dfc_out_if.source  o_out
);

    logic              r_active;
    t_idx              r_idx;
    logic [15:0]       r_crc;
    t_digit_set        r_digits;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              adv;
    logic              cur_active;
    t_idx              cur_idx;
    logic [15:0]       cur_crc;
    t_digit_set        cur_digits;
    logic [BYTE_W-1:0] n_byte;
    logic [15:0]       n_crc;

    assign adv        = !r_out_valid || o_out.ready;
    assign cur_active = r_active || i_up_valid;
    // an idle serializer starts straight on the waiting item
    assign cur_idx    = r_active ? r_idx : '0;
    assign cur_crc    = r_active ? r_crc : '0;
    assign cur_digits = r_active ? r_digits : i_up_digits;
    assign o_up_ready = adv && !r_active;

    always_comb begin
        case (cur_idx)
            5'd0:    n_byte = i_cfg.lead_bytes[47:40];
            5'd1:    n_byte = i_cfg.lead_bytes[39:32];
            5'd2:    n_byte = i_cfg.lead_bytes[31:24];
            5'd3:    n_byte = i_cfg.lead_bytes[23:16];
            5'd4:    n_byte = i_cfg.lead_bytes[15:8];
            5'd5:    n_byte = i_cfg.lead_bytes[7:0];
            5'd6:    n_byte = {4'h0, cur_digits.val_b[3]};
            5'd7:    n_byte = {4'h0, cur_digits.val_b[2]};
            5'd8:    n_byte = {4'h0, cur_digits.val_b[1]};
            5'd9:    n_byte = {4'h0, cur_digits.val_b[0]};
            5'd10:   n_byte = {4'h0, cur_digits.val_a[3]};
            5'd11:   n_byte = {4'h0, cur_digits.val_a[2]};
            5'd12:   n_byte = {4'h0, cur_digits.val_a[1]};
            5'd13:   n_byte = {4'h0, cur_digits.val_a[0]};
            5'd14:   n_byte = i_cfg.trail_byte;
            5'd15:   n_byte = cur_crc[15:8];
            default: n_byte = cur_crc[7:0];
        endcase
    end

    assign n_crc = (cur_idx < IDX_W'(CRC_SPAN)) ? crc_byte(cur_crc, n_byte) : cur_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= cur_active;
            if (cur_active) begin
                r_active <= (cur_idx != IDX_W'(FRAME_LAST));
                r_idx    <= cur_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && cur_active) begin
            r_out_byte <= n_byte;
            r_out_last <= (cur_idx == IDX_W'(FRAME_LAST));
            r_crc      <= n_crc;
            r_digits   <= cur_digits;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.last_byte  = r_out_last;

    // a shown last byte means the frame is closed
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_byte) |-> !r_active)
        else $error("frame still open after last byte");

    // mid-frame index never wraps to byte 0 or past the end
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx != '0 && r_idx <= IDX_W'(FRAME_LAST)))
        else $error("frame index out of range");

    // a new frame opens with lead byte 0
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_up_valid && o_up_ready) |=>
            (o_out.valid && !o_out.last_byte
             && o_out.frame_byte == $past(i_cfg.lead_bytes[47:40])))
        else $error("frame did not start with byte 0");

endmodule
